// ===== src/arpc_pkg.sv =====
// Shared types and constants for the ARP address cache.
`default_nettype none
package arpc_pkg;

	localparam int ENTRIES_DEF = 4;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	localparam logic [23:0] MCAST_OUI    = 24'h01005E;
	localparam logic [3:0]  MCAST_NIBBLE = 4'hE;

	typedef struct packed {
		logic start;
		logic scan;
		logic load;
	} arpc_cmd_t;

	typedef struct packed {
		logic fast;
		logic scan_done;
		logic out_full;
	} arpc_stat_t;

endpackage
`default_nettype wire

// ===== src/arpc_ctrl.sv =====
// Controller for the ARP address cache: accept, table scan, result load.
`default_nettype none
module arpc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   out_ready,
	input  arpc_pkg::arpc_stat_t  stat,
	output arpc_pkg::arpc_cmd_t   cmd
);
	import arpc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.scan  = 1'b0;
		cmd.load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.fast || stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!stat.out_full || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/arpc_dp.sv =====
// Datapath for the ARP address cache: tables, scan compare, result register.
`default_nettype none
module arpc_dp #(
	parameter int Entries = arpc_pkg::ENTRIES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  arpc_pkg::arpc_cmd_t   cmd,
	output arpc_pkg::arpc_stat_t  stat,
	input  wire                   mode,
	input  wire  [31:0]           ip_address,
	input  wire  [47:0]           mac_address,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic                  success,
	output logic [47:0]           resolved_mac
);
	import arpc_pkg::*;

	localparam int IDX_W = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CNT_W = $clog2(Entries + 1);

	logic [31:0] ip_mem  [Entries];
	logic [47:0] mac_mem [Entries];
	logic [Entries-1:0] ent_vld_q;

	logic        mode_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;

	logic [CNT_W-1:0] rd_cnt_q;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_issue;

	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_ent_vld_s1;
	logic [31:0]      rd_ip_s1;
	logic [47:0]      rd_mac_s1;

	logic [31:0] eff_ip;
	logic [47:0] eff_mac;
	logic        cmp_en;
	logic        match;
	logic        empty;
	logic        last;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [47:0]      hit_mac_q;
	logic             emp_q;
	logic [IDX_W-1:0] emp_idx_q;

	logic        is_bcast;
	logic        is_mcast;
	logic        is_zero;
	logic        wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic        res_ok;
	logic [47:0] res_mac;

	logic        out_valid_q;
	logic        success_q;
	logic [47:0] res_mac_q;

	assign rd_issue = cmd.scan && (rd_cnt_q < CNT_W'(Entries));
	assign rd_idx   = rd_cnt_q[IDX_W-1:0];

	// entries never written read as their reset value
	assign eff_ip  = rd_ent_vld_s1 ? rd_ip_s1 : ((rd_idx_s1 == '0) ? '1 : '0);
	assign eff_mac = rd_ent_vld_s1 ? rd_mac_s1 : ((rd_idx_s1 == '0) ? '1 : '0);

	assign cmp_en = cmd.scan && rd_vld_s1;
	assign match  = cmp_en && (eff_ip == ip_q);
	assign empty  = cmp_en && (eff_ip == 32'd0);
	assign last   = (rd_idx_s1 == IDX_W'(Entries - 1));

	assign is_bcast = (ip_q == '1);
	assign is_mcast = (ip_q[31:28] == MCAST_NIBBLE);
	assign is_zero  = (ip_q == 32'd0);

	assign stat.fast      = (mode_q == MODE_LOOKUP) ? (is_bcast || is_mcast || is_zero) : is_zero;
	assign stat.scan_done = cmp_en && (match || last);
	assign stat.out_full  = out_valid_q;

	assign wr_en  = (mode_q == MODE_UPDATE) && !is_zero && (hit_q || emp_q);
	assign wr_idx = hit_q ? hit_idx_q : emp_idx_q;

	always_comb begin
		res_ok  = 1'b0;
		res_mac = 48'd0;
		if (mode_q == MODE_LOOKUP) begin
			if (is_bcast) begin
				res_ok  = 1'b1;
				res_mac = '1;
			end else if (is_mcast) begin
				res_ok  = 1'b1;
				res_mac = {MCAST_OUI, 1'b0, ip_q[22:0]};
			end else if (!is_zero && hit_q) begin
				res_ok  = 1'b1;
				res_mac = hit_mac_q;
			end
		end else begin
			res_ok = wr_en;
		end
	end

	// beat capture and tables
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= mode;
			ip_q   <= ip_address;
			mac_q  <= mac_address;
		end
		rd_idx_s1 <= rd_idx;
		rd_ip_s1  <= ip_mem[rd_idx];
		rd_mac_s1 <= mac_mem[rd_idx];
		rd_ent_vld_s1 <= ent_vld_q[rd_idx];
		if (cmd.load && wr_en) begin
			ip_mem[wr_idx]  <= ip_q;
			mac_mem[wr_idx] <= mac_q;
		end
		if (match && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_mac_q <= eff_mac;
		end
		if (empty && !emp_q) begin
			emp_idx_q <= rd_idx_s1;
		end
		if (cmd.load) begin
			success_q <= res_ok;
			res_mac_q <= res_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q   <= '0;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (cmd.start) begin
				rd_cnt_q <= '0;
				hit_q    <= 1'b0;
				emp_q    <= 1'b0;
			end else begin
				if (rd_issue) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
				if (empty) begin
					emp_q <= 1'b1;
				end
			end
			if (cmd.load && wr_en) begin
				ent_vld_q[wr_idx] <= 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign success      = success_q;
	assign resolved_mac = res_mac_q;

`ifndef ASSERT_OFF
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("result load did not raise out_valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && out_valid_q && !out_ready))
		else $error("result overwritten before taken");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !success_q) |-> (res_mac_q == 48'd0))
		else $error("failed beat carries nonzero mac");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= CNT_W'(Entries))
		else $error("scan counter past table end");
`endif

endmodule
`default_nettype wire

// ===== src/arp_address_cache_unit.sv =====
// ARP address cache: IPv4 to MAC table with broadcast and multicast mapping.
// Broadcast, multicast and zero IP lookups (zero IP only, in update mode) skip the table scan;
//   other items scan the table, one entry per cycle, until a match or the last entry.
// Input waits until the result is loaded; an untaken result holds the next item in S_FIN.
// Reset: arst_n asynchronous; entry 0 reads broadcast/broadcast, others empty.
`default_nettype none
module arp_address_cache_unit #(
	parameter int Entries = arpc_pkg::ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         mode,
	input  wire  [31:0] ip_address,
	input  wire  [47:0] mac_address,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        success,
	output logic [47:0] resolved_mac
);
	import arpc_pkg::*;

	arpc_cmd_t  cmd;
	arpc_stat_t stat;

	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	arpc_dp #(
		.Entries (Entries)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.ip_address   (ip_address),
		.mac_address  (mac_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.success      (success),
		.resolved_mac (resolved_mac)
	);

endmodule
`default_nettype wire
